>>> rtl/qdv_pkg.sv
// Shared types, constants and the transition table of the quadrature decoder.
// Used by every module under rtl; depends on nothing else.
`timescale 1ns / 1ps

package qdv_pkg;

    // Storage widths of the decoder state.
    localparam int POS_W      = 32;
    localparam int TICK_W     = 32;
    localparam int GAIN_W     = 31;
    localparam int OUT_W      = 32;
    localparam int STEP_W     = 2;
    localparam int DIV_CNT_W  = $clog2(GAIN_W);

    // Request queue between the front and the back.
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(65536);

    // Input kind codes as they arrive on the port.
    localparam logic [1:0] KIND_TICK   = 2'd0;
    localparam logic [1:0] KIND_SAMPLE = 2'd1;
    localparam logic [1:0] KIND_CLEAR  = 2'd2;

    typedef logic signed [STEP_W-1:0] t_step;

    // Classified request handed from the front to the back.
    typedef enum logic [1:0] {
        CMD_TICK,
        CMD_SAMPLE,
        CMD_CLEAR,
        CMD_NOP
    } t_cmd;

    typedef struct packed {
        t_cmd       cmd;
        logic [1:0] ab;
    } t_cmd_item;

    // Start request for the iterative divider.
    typedef struct packed {
        logic              start;
        logic [GAIN_W-1:0] dividend;
        logic [TICK_W-1:0] divisor;
    } t_div_req;

    typedef enum logic {
        ST_IDLE,
        ST_DIVIDE
    } t_back_state;

    // Step for each (old AB, new AB) pair, index is {old, new}.
    localparam t_step STEP_TABLE [16] = '{
         2'sd0, -2'sd1,  2'sd1,  2'sd0,
         2'sd1,  2'sd0,  2'sd0, -2'sd1,
        -2'sd1,  2'sd0,  2'sd0,  2'sd1,
         2'sd0,  2'sd1, -2'sd1,  2'sd0
    };

    function automatic t_step step_lookup(input logic [1:0] old_ab, input logic [1:0] new_ab);
        return STEP_TABLE[{old_ab, new_ab}];
    endfunction

endpackage

>>> rtl/qdv_front.sv
// Front end: takes input requests and classifies them into decoder commands.
// Depends on qdv_pkg; feeds qdv_fifo.
`timescale 1ns / 1ps

module qdv_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [1:0]           i_kind,
    input  logic                 i_pin_a,
    input  logic                 i_pin_b,
    input  logic                 i_full,
    output logic                 o_push,
    output qdv_pkg::t_cmd_item   o_push_item
);

    logic                r_valid;
    logic                n_valid;
    qdv_pkg::t_cmd_item  r_item;
    qdv_pkg::t_cmd_item  n_item;
    qdv_pkg::t_cmd       w_cmd;

    // Map the raw kind code onto a command.
    always_comb begin
        case (i_kind)
            qdv_pkg::KIND_TICK:   w_cmd = qdv_pkg::CMD_TICK;
            qdv_pkg::KIND_SAMPLE: w_cmd = qdv_pkg::CMD_SAMPLE;
            qdv_pkg::KIND_CLEAR:  w_cmd = qdv_pkg::CMD_CLEAR;
            default:              w_cmd = qdv_pkg::CMD_NOP;
        endcase
    end

    // The holding register drains into the queue whenever the queue has room.
    assign o_push      = r_valid && !i_full;
    assign o_push_item = r_item;
    assign o_in_stall  = r_valid && i_full;

    always_comb begin
        n_valid = r_valid;
        n_item  = r_item;
        if (o_push) begin
            n_valid = 1'b0;
        end
        if (i_in_valid && !o_in_stall) begin
            n_valid     = 1'b1;
            n_item.cmd  = w_cmd;
            n_item.ab   = {i_pin_a, i_pin_b};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_item <= n_item;
    end

endmodule

>>> rtl/qdv_fifo.sv
// Short command queue that decouples the front end from the back end.
// Depends on qdv_pkg.
`timescale 1ns / 1ps

module qdv_fifo (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  qdv_pkg::t_cmd_item   i_push_item,
    output logic                 o_full,
    input  logic                 i_pop,
    output qdv_pkg::t_cmd_item   o_pop_item,
    output logic                 o_empty
);

    qdv_pkg::t_cmd_item              r_mem [qdv_pkg::FIFO_DEPTH];
    logic [qdv_pkg::FIFO_AW-1:0]     r_wr_ptr;
    logic [qdv_pkg::FIFO_AW-1:0]     r_rd_ptr;
    logic [qdv_pkg::FIFO_AW:0]       r_count;
    logic [qdv_pkg::FIFO_AW-1:0]     n_wr_ptr;
    logic [qdv_pkg::FIFO_AW-1:0]     n_rd_ptr;
    logic [qdv_pkg::FIFO_AW:0]       n_count;

    assign o_full     = (r_count == (qdv_pkg::FIFO_AW+1)'(qdv_pkg::FIFO_DEPTH));
    assign o_empty    = (r_count == '0);
    assign o_pop_item = r_mem[r_rd_ptr];

    // Pointer and fill count update.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_item;
        end
    end

endmodule

>>> rtl/qdv_div.sv
// Restoring divider, one quotient bit per cycle: gain over elapsed ticks.
// Depends on qdv_pkg; used by qdv_back.
`timescale 1ns / 1ps

module qdv_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  qdv_pkg::t_div_req             i_req,
    output logic                          o_done,
    output logic [qdv_pkg::GAIN_W-1:0]    o_quot
);

    logic                              r_busy;
    logic                              r_done;
    logic [qdv_pkg::DIV_CNT_W-1:0]     r_cnt;
    logic [qdv_pkg::GAIN_W-1:0]        r_dividend;
    logic [qdv_pkg::TICK_W-1:0]        r_divisor;
    logic [qdv_pkg::TICK_W-1:0]        r_rem;
    logic [qdv_pkg::GAIN_W-1:0]        r_quot;
    logic                              n_busy;
    logic                              n_done;
    logic [qdv_pkg::DIV_CNT_W-1:0]     n_cnt;
    logic [qdv_pkg::GAIN_W-1:0]        n_dividend;
    logic [qdv_pkg::TICK_W-1:0]        n_divisor;
    logic [qdv_pkg::TICK_W-1:0]        n_rem;
    logic [qdv_pkg::GAIN_W-1:0]        n_quot;
    logic [qdv_pkg::TICK_W:0]          w_trial;
    logic                              w_fit;

    // Bring down the next dividend bit and try a subtract.
    assign w_trial = {r_rem, r_dividend[qdv_pkg::GAIN_W-1]};
    assign w_fit   = (w_trial >= {1'b0, r_divisor});

    always_comb begin
        n_busy     = r_busy;
        n_done     = 1'b0;
        n_cnt      = r_cnt;
        n_dividend = r_dividend;
        n_divisor  = r_divisor;
        n_rem      = r_rem;
        n_quot     = r_quot;
        if (i_req.start) begin
            n_busy     = 1'b1;
            n_cnt      = qdv_pkg::DIV_CNT_W'(qdv_pkg::GAIN_W - 1);
            n_dividend = i_req.dividend;
            n_divisor  = i_req.divisor;
            n_rem      = '0;
            n_quot     = '0;
        end else if (r_busy) begin
            n_rem      = w_fit ? qdv_pkg::TICK_W'(w_trial - {1'b0, r_divisor})
                               : qdv_pkg::TICK_W'(w_trial);
            n_quot     = {r_quot[qdv_pkg::GAIN_W-2:0], w_fit};
            n_dividend = {r_dividend[qdv_pkg::GAIN_W-2:0], 1'b0};
            n_cnt      = r_cnt - 1'b1;
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt      <= n_cnt;
        r_dividend <= n_dividend;
        r_divisor  <= n_divisor;
        r_rem      <= n_rem;
        r_quot     <= n_quot;
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

>>> rtl/qdv_back.sv
// Back end: holds the decoder state, executes commands and owns the result register.
// Depends on qdv_pkg and qdv_div.
`timescale 1ns / 1ps

module qdv_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [qdv_pkg::GAIN_W-1:0]    i_gain,
    input  logic                          i_empty,
    input  qdv_pkg::t_cmd_item            i_item,
    output logic                          o_pop,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic signed [qdv_pkg::OUT_W-1:0] o_position,
    output logic signed [qdv_pkg::OUT_W-1:0] o_velocity,
    output logic signed [qdv_pkg::STEP_W-1:0] o_step
);

    qdv_pkg::t_back_state              r_state;
    qdv_pkg::t_back_state              n_state;
    logic [1:0]                        r_last_ab;
    logic [1:0]                        n_last_ab;
    logic                              r_ab_known;
    logic                              n_ab_known;
    logic [qdv_pkg::POS_W-1:0]         r_step_total;
    logic [qdv_pkg::POS_W-1:0]         n_step_total;
    logic [qdv_pkg::OUT_W-1:0]         r_speed;
    logic [qdv_pkg::OUT_W-1:0]         n_speed;
    logic [qdv_pkg::TICK_W-1:0]        r_ticks;
    logic [qdv_pkg::TICK_W-1:0]        n_ticks;
    logic                              r_neg;
    logic                              n_neg;
    qdv_pkg::t_step                    r_pend_step;
    qdv_pkg::t_step                    n_pend_step;
    logic                              r_out_valid;
    logic                              n_out_valid;
    logic [qdv_pkg::OUT_W-1:0]         r_out_position;
    logic [qdv_pkg::OUT_W-1:0]         n_out_position;
    logic [qdv_pkg::OUT_W-1:0]         r_out_velocity;
    logic [qdv_pkg::OUT_W-1:0]         n_out_velocity;
    qdv_pkg::t_step                    r_out_step;
    qdv_pkg::t_step                    n_out_step;
    logic                              w_slot_free;
    qdv_pkg::t_step                    w_step;
    qdv_pkg::t_div_req                 w_div_req;
    logic                              w_div_done;
    logic [qdv_pkg::GAIN_W-1:0]        w_div_quot;
    logic [qdv_pkg::OUT_W-1:0]         w_mag;

    qdv_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_done  (w_div_done),
        .o_quot  (w_div_quot)
    );

    // The result slot is free when empty or being taken this cycle.
    assign w_slot_free = !r_out_valid || !i_out_stall;
    assign o_pop       = (r_state == qdv_pkg::ST_IDLE) && !i_empty && w_slot_free;
    assign w_step      = qdv_pkg::step_lookup(r_last_ab, i_item.ab);
    assign w_mag       = qdv_pkg::OUT_W'({1'b0, w_div_quot});

    // Command execution and result capture.
    always_comb begin
        n_state            = r_state;
        n_last_ab          = r_last_ab;
        n_ab_known         = r_ab_known;
        n_step_total       = r_step_total;
        n_speed            = r_speed;
        n_ticks            = r_ticks;
        n_neg              = r_neg;
        n_pend_step        = r_pend_step;
        n_out_valid        = r_out_valid && i_out_stall;
        n_out_position     = r_out_position;
        n_out_velocity     = r_out_velocity;
        n_out_step         = r_out_step;
        w_div_req.start    = 1'b0;
        w_div_req.dividend = i_gain;
        w_div_req.divisor  = r_ticks;

        case (r_state)
            qdv_pkg::ST_IDLE: begin
                if (o_pop) begin
                    n_pend_step = '0;
                    case (i_item.cmd)
                        qdv_pkg::CMD_TICK: begin
                            if (r_ticks != '1) begin
                                n_ticks = r_ticks + 1'b1;
                            end
                        end
                        qdv_pkg::CMD_SAMPLE: begin
                            if (!r_ab_known) begin
                                n_last_ab  = i_item.ab;
                                n_ab_known = 1'b1;
                                n_ticks    = '0;
                            end else if (i_item.ab != r_last_ab) begin
                                n_pend_step = w_step;
                                n_step_total = r_step_total
                                             + qdv_pkg::POS_W'(signed'(w_step));
                                n_last_ab = i_item.ab;
                                n_ticks   = '0;
                                if (r_ticks == '0 || w_step == '0) begin
                                    n_speed = '0;
                                end else begin
                                    // Velocity needs gain / ticks; hand it to the divider.
                                    w_div_req.start = 1'b1;
                                    n_neg           = w_step[qdv_pkg::STEP_W-1];
                                    n_state         = qdv_pkg::ST_DIVIDE;
                                end
                            end
                        end
                        qdv_pkg::CMD_CLEAR: begin
                            n_step_total = '0;
                            n_speed      = '0;
                        end
                        default: begin
                        end
                    endcase
                    if (n_state == qdv_pkg::ST_IDLE) begin
                        n_out_valid    = 1'b1;
                        n_out_position = qdv_pkg::OUT_W'(signed'(n_step_total));
                        n_out_velocity = n_speed;
                        n_out_step     = n_pend_step;
                    end
                end
            end
            qdv_pkg::ST_DIVIDE: begin
                if (w_div_done) begin
                    n_speed        = r_neg ? (qdv_pkg::OUT_W'(0) - w_mag) : w_mag;
                    n_out_valid    = 1'b1;
                    n_out_position = qdv_pkg::OUT_W'(signed'(r_step_total));
                    n_out_velocity = n_speed;
                    n_out_step     = r_pend_step;
                    n_state        = qdv_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = qdv_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= qdv_pkg::ST_IDLE;
            r_last_ab    <= '0;
            r_ab_known   <= 1'b0;
            r_step_total <= '0;
            r_speed      <= '0;
            r_ticks      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_last_ab    <= n_last_ab;
            r_ab_known   <= n_ab_known;
            r_step_total <= n_step_total;
            r_speed      <= n_speed;
            r_ticks      <= n_ticks;
            r_out_valid  <= n_out_valid;
        end
        r_neg          <= n_neg;
        r_pend_step    <= n_pend_step;
        r_out_position <= n_out_position;
        r_out_velocity <= n_out_velocity;
        r_out_step     <= n_out_step;
    end

    assign o_out_valid = r_out_valid;
    assign o_position  = signed'(r_out_position);
    assign o_velocity  = signed'(r_out_velocity);
    assign o_step      = r_out_step;

    // A request is only taken while idle and with room for its result.
    a_pop_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> (r_state == qdv_pkg::ST_IDLE) && w_slot_free)
        else $error("request taken while busy or result slot full");

    // The divider finishes only while a division is outstanding.
    a_done_in_divide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == qdv_pkg::ST_DIVIDE))
        else $error("divider finished outside a division");

    // While dividing, the result slot stays empty.
    a_slot_empty_divide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == qdv_pkg::ST_DIVIDE) |-> !r_out_valid)
        else $error("result pending during a division");

    // A reported step is never the unused code.
    a_step_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_step != 2'b10))
        else $error("illegal step code in result");

endmodule

>>> rtl/quadrature_decoder_with_velocity.sv
// Top level of the x4 quadrature decoder with velocity estimate.
// Depends on qdv_pkg, qdv_front, qdv_fifo and qdv_back (with qdv_div).
//
//  Channel   Direction  Handshake               Payload
//  input     in         i_in_valid / o_in_stall i_kind, i_pin_a, i_pin_b
//  result    out        o_out_valid / i_out_stall o_position, o_velocity, o_step
//  config    in         i_cfg_valid / o_cfg_ready i_cfg_data (velocity gain)
//
// A tick, clear, no-op, unchanged or first sample shows its result without a division.
// A sample that moves the position with elapsed ticks runs the one-bit-per-cycle
// divider (31 steps); its result is registered when the divider reports done, and the
// back end runs one request at a time.
// Reset is synchronous and active low; it clears the decoder state and the valid flags (not the
// data registers) and sets gain to 65536. The front register and four queue entries hold requests
// ahead of the back end; a stalled result stops intake only once they are all full.
`timescale 1ns / 1ps

module quadrature_decoder_with_velocity (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_kind,
    input  logic        i_pin_a,
    input  logic        i_pin_b,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic signed [31:0] o_position,
    output logic signed [31:0] o_velocity,
    output logic signed [1:0]  o_step,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [30:0] i_cfg_data
);

    logic [qdv_pkg::GAIN_W-1:0]  r_gain;
    logic                        w_push;
    qdv_pkg::t_cmd_item          w_push_item;
    logic                        w_full;
    logic                        w_pop;
    qdv_pkg::t_cmd_item          w_pop_item;
    logic                        w_empty;

    // Gain register; writes must arrive only while the decoder is idle; nothing enforces it.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= qdv_pkg::GAIN_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_gain <= i_cfg_data;
        end
    end

    qdv_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_kind      (i_kind),
        .i_pin_a     (i_pin_a),
        .i_pin_b     (i_pin_b),
        .i_full      (w_full),
        .o_push      (w_push),
        .o_push_item (w_push_item)
    );

    qdv_fifo u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_item (w_push_item),
        .o_full      (w_full),
        .i_pop       (w_pop),
        .o_pop_item  (w_pop_item),
        .o_empty     (w_empty)
    );

    qdv_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_gain      (r_gain),
        .i_empty     (w_empty),
        .i_item      (w_pop_item),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_position  (o_position),
        .o_velocity  (o_velocity),
        .o_step      (o_step)
    );

endmodule
